// ===== src/fdtd_pkg.sv =====
// ----------------------------------------------------------------------------
// fdtd_pkg: shared types and constants of the 2D FDTD E-field update core
// Field and coefficient formats, register map, cell and pipeline structs.
// ----------------------------------------------------------------------------
package fdtd_pkg;

  // Field format: signed Q16.16.
  localparam int FIELD_W    = 32;
  // Line buffer depth and its address width.
  localparam int LINE_DEPTH = 1024;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  // Grid position counters and extent registers.
  localparam int POS_W      = 10;
  localparam int EXT_W      = 11;
  localparam int MARGIN_W   = 6;
  localparam int MAX_EXTENT = 1024;
  // Coefficient format: unsigned Q12.20.
  localparam int COEF_W     = 32;
  localparam int FRAC_SHIFT = 20;

  // Datapath widths: difference magnitude, product, rounded term, sum.
  localparam int MAG_W  = FIELD_W + 1;
  localparam int PROD_W = MAG_W + COEF_W;
  localparam int RND_W  = PROD_W - FRAC_SHIFT;
  localparam int TERM_W = RND_W + 1;
  localparam int SUM_W  = TERM_W + 2;

  // Scaled terms of the three update equations.
  localparam int NUM_TERMS  = 7;
  localparam int TERM_IDX_W = $clog2(NUM_TERMS);
  localparam logic [TERM_IDX_W-1:0] T_X_CURL  = 3'd0;  // Cy * (Hz - Hz left)
  localparam logic [TERM_IDX_W-1:0] T_X_CUR   = 3'd1;  // Cj * Jx
  localparam logic [TERM_IDX_W-1:0] T_Y_CURL  = 3'd2;  // Cx * (Hz - Hz above)
  localparam logic [TERM_IDX_W-1:0] T_Y_CUR   = 3'd3;  // Cj * Jy
  localparam logic [TERM_IDX_W-1:0] T_Z_CURLY = 3'd4;  // Cx * (Hy - Hy above)
  localparam logic [TERM_IDX_W-1:0] T_Z_CURLX = 3'd5;  // Cy * (Hx - Hx left)
  localparam logic [TERM_IDX_W-1:0] T_Z_CUR   = 3'd6;  // Cj * Jz

  // APB register map, one 32-bit word per register.
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_ROWS   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MARGIN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CX     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CY     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CJ     = 3'd5;

  localparam logic [EXT_W-1:0] ROWS_RESET = 11'd256;
  localparam logic [EXT_W-1:0] COLS_RESET = 11'd256;

  typedef logic signed [FIELD_W-1:0] field_t;

  // One grid cell; ex_in sits in the lowest bits.
  typedef struct packed {
    field_t jz;
    field_t jy;
    field_t jx;
    field_t hz;
    field_t hy;
    field_t hx;
    field_t ez;
    field_t ey;
    field_t ex;
  } cell_t;

  typedef struct packed {
    logic [EXT_W-1:0]    rows;
    logic [EXT_W-1:0]    cols;
    logic [MARGIN_W-1:0] margin;
    logic [COEF_W-1:0]   cx;
    logic [COEF_W-1:0]   cy;
    logic [COEF_W-1:0]   cj;
  } cfg_t;

  // Which fields of a cell get updated, and the frame end mark.
  typedef struct packed {
    logic x;
    logic y;
    logic z;
    logic last;
  } upd_t;

  // Cell with its neighbor values, as handed from the front end.
  typedef struct packed {
    cell_t  site;
    field_t hz_left;
    field_t hx_left;
    field_t hz_up;
    field_t hy_up;
    upd_t   upd;
  } nbr_t;

endpackage

// ===== src/fdtd_ram.sv =====
// ----------------------------------------------------------------------------
// fdtd_ram: generic simple dual-port RAM
// One write port and one read port, read data registered, old data returned
// when the read and the write hit the same entry in one cycle.
// ----------------------------------------------------------------------------
module fdtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/fdtd_cfg.sv =====
// ----------------------------------------------------------------------------
// fdtd_cfg: APB configuration registers
// Grid extents, margin and the three update coefficients.
// ----------------------------------------------------------------------------
module fdtd_cfg import fdtd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[APB_AW-1:2];

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows   <= ROWS_RESET;
      cfg.cols   <= COLS_RESET;
      cfg.margin <= '0;
      cfg.cx     <= '0;
      cfg.cy     <= '0;
      cfg.cj     <= '0;
    end else if (wr) begin
      case (idx)
        REG_ROWS:   cfg.rows   <= pwdata[EXT_W-1:0];
        REG_COLS:   cfg.cols   <= pwdata[EXT_W-1:0];
        REG_MARGIN: cfg.margin <= pwdata[MARGIN_W-1:0];
        REG_CX:     cfg.cx     <= pwdata[COEF_W-1:0];
        REG_CY:     cfg.cy     <= pwdata[COEF_W-1:0];
        REG_CJ:     cfg.cj     <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (idx)
      REG_ROWS:   prdata = APB_DW'(cfg.rows);
      REG_COLS:   prdata = APB_DW'(cfg.cols);
      REG_MARGIN: prdata = APB_DW'(cfg.margin);
      REG_CX:     prdata = APB_DW'(cfg.cx);
      REG_CY:     prdata = APB_DW'(cfg.cy);
      REG_CJ:     prdata = APB_DW'(cfg.cj);
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== src/fdtd_front.sv =====
// ----------------------------------------------------------------------------
// fdtd_front: grid position tracking and neighbor lookup
// Keeps the row and column counters, the Hz/Hy line buffers of the row above
// and the Hz/Hx values of the cell to the left, and decides per field whether
// the cell lies inside its update range.
// ----------------------------------------------------------------------------
module fdtd_front import fdtd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  accept,
  input  cell_t cell_in,
  output nbr_t  nbr
);

  localparam int CMP_W = EXT_W + 1;

  logic [POS_W-1:0]   row_pos;
  logic [POS_W-1:0]   col_pos;
  logic [EXT_W-1:0]   fill;
  logic [LINE_AW-1:0] slot;
  logic [EXT_W-1:0]   rows_e;
  logic [EXT_W-1:0]   cols_e;
  logic [EXT_W-1:0]   col_inc;
  logic [EXT_W-1:0]   row_inc;
  logic [CMP_W-1:0]   row_far;
  logic [CMP_W-1:0]   col_far;
  logic               i_full;
  logic               i_in;
  logic               j_full;
  logic               j_in;
  logic               last_col;
  logic               last_row;
  logic               up_ok;
  logic               up_ok_next;
  field_t             hz_left;
  field_t             hx_left;
  field_t             hz_left_out;
  field_t             hx_left_out;
  field_t             hz_ram;
  field_t             hy_ram;
  cell_t              site;
  upd_t               upd;

  function automatic logic [EXT_W-1:0] extent(input logic [EXT_W-1:0] v);
    if (v == '0) begin
      return EXT_W'(1);
    end
    if (v > EXT_W'(MAX_EXTENT)) begin
      return EXT_W'(MAX_EXTENT);
    end
    return v;
  endfunction

  // Range decisions for the cell at the current position.
  always_comb begin
    rows_e   = extent(cfg.rows);
    cols_e   = extent(cfg.cols);
    slot     = col_pos[LINE_AW-1:0];
    row_far  = CMP_W'(row_pos) + CMP_W'(cfg.margin);
    col_far  = CMP_W'(col_pos) + CMP_W'(cfg.margin);
    i_full   = (row_pos >= POS_W'(cfg.margin)) && (row_far < CMP_W'(rows_e));
    i_in     = (row_pos >  POS_W'(cfg.margin)) && (row_far < CMP_W'(rows_e));
    j_full   = (col_pos >= POS_W'(cfg.margin)) && (col_far < CMP_W'(cols_e));
    j_in     = (col_pos >  POS_W'(cfg.margin)) && (col_far < CMP_W'(cols_e));
    col_inc  = EXT_W'(col_pos) + EXT_W'(1);
    row_inc  = EXT_W'(row_pos) + EXT_W'(1);
    last_col = col_inc >= cols_e;
    last_row = row_inc >= rows_e;
    // Line buffer entries are written in column order from zero upward, so
    // everything below the fill count holds data and the rest reads as zero.
    up_ok_next = EXT_W'(col_pos) < fill;
  end

  // Position counters and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
      fill    <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_pos <= '0;
        row_pos <= last_row ? '0 : row_inc[POS_W-1:0];
      end else begin
        col_pos <= col_inc[POS_W-1:0];
      end
      if (col_inc > fill) begin
        fill <= col_inc;
      end
    end
  end

  // Left-neighbor registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hz_left <= '0;
      hx_left <= '0;
    end else if (accept) begin
      hz_left <= cell_in.hz;
      hx_left <= cell_in.hx;
    end
  end

  // Cell register, aligned with the line buffer read data.
  always_ff @(posedge clk) begin
    if (accept) begin
      site         <= cell_in;
      hz_left_out  <= hz_left;
      hx_left_out  <= hx_left;
      up_ok        <= up_ok_next;
      upd.x        <= i_full & j_in;
      upd.y        <= i_in & j_full;
      upd.z        <= i_in & j_in;
      upd.last     <= last_col & last_row;
    end
  end

  // Line buffers: read the row above and overwrite it with this row.
  fdtd_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (LINE_DEPTH)
  ) u_hz_line (
    .clk   (clk),
    .we    (accept),
    .waddr (slot),
    .wdata (cell_in.hz),
    .re    (accept),
    .raddr (slot),
    .rdata (hz_ram)
  );

  fdtd_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (LINE_DEPTH)
  ) u_hy_line (
    .clk   (clk),
    .we    (accept),
    .waddr (slot),
    .wdata (cell_in.hy),
    .re    (accept),
    .raddr (slot),
    .rdata (hy_ram)
  );

  assign nbr.site    = site;
  assign nbr.hz_left = hz_left_out;
  assign nbr.hx_left = hx_left_out;
  assign nbr.upd     = upd;
  assign nbr.hz_up   = up_ok ? hz_ram : '0;
  assign nbr.hy_up   = up_ok ? hy_ram : '0;

endmodule

// ===== src/fdtd_dp.sv =====
// ----------------------------------------------------------------------------
// fdtd_dp: arithmetic pipeline and output register
// Differences, coefficient products, rounding and saturating sums, with a
// valid bit per stage and back pressure from the output side.
// ----------------------------------------------------------------------------
module fdtd_dp import fdtd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nbr_t                 nbr,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [3*FIELD_W-1:0] m_tdata,
  output logic                 m_tlast
);

  localparam logic [NUM_TERMS-1:0] TERM_SUB  = 7'b1101110;
  localparam logic [PROD_W-1:0]    ROUND_ADD = PROD_W'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'({1'b0, {(FIELD_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

  logic v1;
  logic v2;
  logic v3;
  logic v4;
  logic rdy_o;
  logic rdy2;
  logic rdy3;
  logic rdy4;

  logic signed [MAG_W-1:0]  diff [NUM_TERMS];
  logic [MAG_W-1:0]         mag2 [NUM_TERMS];
  logic [NUM_TERMS-1:0]     neg2;
  logic [PROD_W-1:0]        prod3 [NUM_TERMS];
  logic [NUM_TERMS-1:0]     neg3;
  logic signed [TERM_W-1:0] term4 [NUM_TERMS];
  field_t ex2, ey2, ez2, ex3, ey3, ez3, ex4, ey4, ez4;
  upd_t   upd2, upd3, upd4;
  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;
  logic signed [SUM_W-1:0]  sum_z;
  field_t ex_res, ey_res, ez_res;

  function automatic logic [COEF_W-1:0] lane_coef(input logic [TERM_IDX_W-1:0] lane,
                                                  input cfg_t c);
    case (lane)
      T_X_CURL:  return c.cy;
      T_Y_CURL:  return c.cx;
      T_Z_CURLY: return c.cx;
      T_Z_CURLX: return c.cy;
      default:   return c.cj;
    endcase
  endfunction

  function automatic field_t sat(input logic signed [SUM_W-1:0] s);
    if (s > SAT_MAX) begin
      return SAT_MAX[FIELD_W-1:0];
    end
    if (s < SAT_MIN) begin
      return SAT_MIN[FIELD_W-1:0];
    end
    return s[FIELD_W-1:0];
  endfunction

  // Stage handshake: a stage takes new data when it is empty or moving on.
  assign rdy_o    = !m_tvalid || m_tready;
  assign rdy4     = !v4 || rdy_o;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign in_ready = !v1 || rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_ready) v1       <= in_valid;
      if (rdy2)     v2       <= v1;
      if (rdy3)     v3       <= v2;
      if (rdy4)     v4       <= v3;
      if (rdy_o)    m_tvalid <= v4;
    end
  end

  // Exact differences and current densities, widened by one bit.
  always_comb begin
    diff[T_X_CURL]  = MAG_W'(nbr.site.hz) - MAG_W'(nbr.hz_left);
    diff[T_X_CUR]   = MAG_W'(nbr.site.jx);
    diff[T_Y_CURL]  = MAG_W'(nbr.site.hz) - MAG_W'(nbr.hz_up);
    diff[T_Y_CUR]   = MAG_W'(nbr.site.jy);
    diff[T_Z_CURLY] = MAG_W'(nbr.site.hy) - MAG_W'(nbr.hy_up);
    diff[T_Z_CURLX] = MAG_W'(nbr.site.hx) - MAG_W'(nbr.hx_left);
    diff[T_Z_CUR]   = MAG_W'(nbr.site.jz);
  end

  // Stage 2: magnitude and final sign of each term.
  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        mag2[k] <= diff[k][MAG_W-1] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
        neg2[k] <= diff[k][MAG_W-1] ^ TERM_SUB[k];
      end
      ex2  <= nbr.site.ex;
      ey2  <= nbr.site.ey;
      ez2  <= nbr.site.ez;
      upd2 <= nbr.upd;
    end
  end

  // Stage 3: coefficient products of the magnitudes.
  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        prod3[k] <= mag2[k] * lane_coef(TERM_IDX_W'(k), cfg);
      end
      neg3 <= neg2;
      ex3  <= ex2;
      ey3  <= ey2;
      ez3  <= ez2;
      upd3 <= upd2;
    end
  end

  // Stage 4: round the magnitude half away from zero, then apply the sign.
  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        term4[k] <= neg3[k]
          ? -$signed({1'b0, RND_W'((prod3[k] + ROUND_ADD) >> FRAC_SHIFT)})
          :  $signed({1'b0, RND_W'((prod3[k] + ROUND_ADD) >> FRAC_SHIFT)});
      end
      ex4  <= ex3;
      ey4  <= ey3;
      ez4  <= ez3;
      upd4 <= upd3;
    end
  end

  // Exact sums, saturation and the pass-through choice.
  always_comb begin
    sum_x  = SUM_W'(ex4) + SUM_W'(term4[T_X_CURL]) + SUM_W'(term4[T_X_CUR]);
    sum_y  = SUM_W'(ey4) + SUM_W'(term4[T_Y_CURL]) + SUM_W'(term4[T_Y_CUR]);
    sum_z  = SUM_W'(ez4) + SUM_W'(term4[T_Z_CURLY]) + SUM_W'(term4[T_Z_CURLX])
           + SUM_W'(term4[T_Z_CUR]);
    ex_res = upd4.x ? sat(sum_x) : ex4;
    ey_res = upd4.y ? sat(sum_y) : ey4;
    ez_res = upd4.z ? sat(sum_z) : ez4;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rdy_o && v4) begin
      m_tdata <= {ez_res, ey_res, ex_res};
      m_tlast <= upd4.last;
    end
  end

endmodule

// ===== src/fdtd2d_e_field_update_core.sv =====
// ----------------------------------------------------------------------------
// fdtd2d_e_field_update_core: streaming 2D Yee-grid E-field update
// Top level: APB registers, position tracking with line buffers, and the
// arithmetic pipeline.
// ----------------------------------------------------------------------------
// The core takes one grid cell per clock cycle unless stalled, in row-major
// order, and returns one cell of updated Ex, Ey, Ez per request through the
// pipeline and its output register. The two 1024 x 32 line buffers (Hz and
// Hy of the row above) are each read and written once per cell at the column
// position; the cell to the left comes from registers. Back pressure on the
// output stalls the pipeline stage by stage, so requests keep flowing into
// empty stages while a finished result waits. After reset the line buffers
// read as zero until each column has been written once, tracked by a fill
// count, so no clearing pass is needed. Cells outside the margin-bounded
// interior of each field pass through unchanged; m_tlast marks the last cell
// of the frame. Write the registers only while the core is idle.
// ----------------------------------------------------------------------------
module fdtd2d_e_field_update_core import fdtd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Cell stream in.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // ex_in, ey_in, ez_in, hx_in, hy_in, hz_in, jx_in, jy_in, jz_in
  input  logic [9*FIELD_W-1:0] s_tdata,
  // Updated field stream out.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // ex_out, ey_out, ez_out
  output logic [3*FIELD_W-1:0] m_tdata,
  // frame_end
  output logic                 m_tlast,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  cfg_t  cfg;
  nbr_t  nbr;
  logic  accept;

  assign accept = s_tvalid & s_tready;

  fdtd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fdtd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .cell_in (cell_t'(s_tdata)),
    .nbr     (nbr)
  );

  fdtd_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .nbr      (nbr),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
